@@ rtl/jse_pkg.sv @@
// Shared types, character constants and helper functions for the JSON string escaper.
`timescale 1ns / 1ps
`default_nettype none

package jse_pkg;

   localparam int QUEUE_DEPTH = 2;

   // Input function codes
   localparam logic FUNC_BYTE  = 1'b0;
   localparam logic FUNC_EMPTY = 1'b1;

   localparam logic [7:0] CHR_QUOTE  = 8'h22;
   localparam logic [7:0] CHR_BSLASH = 8'h5C;
   localparam logic [7:0] CHR_U      = 8'h75;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_B      = 8'h62;
   localparam logic [7:0] CHR_F      = 8'h66;
   localparam logic [7:0] CHR_N      = 8'h6E;
   localparam logic [7:0] CHR_R      = 8'h72;
   localparam logic [7:0] CHR_T      = 8'h74;

   localparam logic [7:0] CODE_BS = 8'h08;
   localparam logic [7:0] CODE_TAB = 8'h09;
   localparam logic [7:0] CODE_LF = 8'h0A;
   localparam logic [7:0] CODE_FF = 8'h0C;
   localparam logic [7:0] CODE_CR = 8'h0D;

   localparam logic [7:0] CTRL_LIMIT = 8'h20;
   localparam logic [7:0] HIGH_LIMIT = 8'h80;

   typedef enum logic [1:0] {
      ESC_NONE,   // no body, only quotes (empty string)
      ESC_PLAIN,  // byte passes as is
      ESC_PAIR,   // backslash + tag
      ESC_UNI     // \u00XX
   } esc_kind_type;

   typedef struct packed {
      esc_kind_type kind;
      logic [7:0]   ch;       // raw byte, or tag for a pair escape
      logic         open_q;
      logic         close_q;
   } desc_type;

   function automatic logic [2:0] esc_len(input esc_kind_type kind);
      logic [2:0] len;
      unique case (kind)
         ESC_NONE:  len = 3'd0;
         ESC_PLAIN: len = 3'd1;
         ESC_PAIR:  len = 3'd2;
         ESC_UNI:   len = 3'd6;
         default:   len = 3'd0;
      endcase
      return len;
   endfunction

   // Lowercase hex character for one nibble
   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] digit;
      if (nib < 4'd10) begin
         digit = CHR_ZERO + {4'h0, nib};
      end else begin
         digit = 8'h57 + {4'h0, nib};
      end
      return digit;
   endfunction

endpackage

`default_nettype wire

@@ rtl/jse_stream_if.sv @@
// Valid/ready channel interfaces for the request and response streams.
`timescale 1ns / 1ps
`default_nettype none

interface jse_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] data_byte;
   logic       first_byte;
   logic       last_byte;

   modport source (output valid, func, data_byte, first_byte, last_byte, input ready);
   modport sink   (input valid, func, data_byte, first_byte, last_byte, output ready);
endinterface

interface jse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_end;

   modport source (output valid, out_byte, run_end, input ready);
   modport sink   (input valid, out_byte, run_end, output ready);
endinterface

`default_nettype wire

@@ rtl/jse_front.sv @@
// Front end: accepts request transactions and classifies each byte's escape form.
`timescale 1ns / 1ps
`default_nettype none

module jse_front (
   jse_req_if.sink               req,
   output logic                  push_valid,
   input  logic                  push_ready,
   output jse_pkg::desc_type     push_data
);

   assign push_valid = req.valid;
   assign req.ready  = push_ready;

   always_comb begin
      push_data.ch      = req.data_byte;
      push_data.open_q  = req.first_byte;
      push_data.close_q = req.last_byte;
      push_data.kind    = jse_pkg::ESC_PLAIN;
      if (req.func == jse_pkg::FUNC_EMPTY) begin
         push_data.kind    = jse_pkg::ESC_NONE;
         push_data.open_q  = 1'b1;
         push_data.close_q = 1'b1;
      end else begin
         unique case (req.data_byte)
            jse_pkg::CHR_QUOTE: begin
               push_data.kind = jse_pkg::ESC_PAIR;
               push_data.ch   = jse_pkg::CHR_QUOTE;
            end
            jse_pkg::CHR_BSLASH: begin
               push_data.kind = jse_pkg::ESC_PAIR;
               push_data.ch   = jse_pkg::CHR_BSLASH;
            end
            jse_pkg::CODE_BS: begin
               push_data.kind = jse_pkg::ESC_PAIR;
               push_data.ch   = jse_pkg::CHR_B;
            end
            jse_pkg::CODE_FF: begin
               push_data.kind = jse_pkg::ESC_PAIR;
               push_data.ch   = jse_pkg::CHR_F;
            end
            jse_pkg::CODE_LF: begin
               push_data.kind = jse_pkg::ESC_PAIR;
               push_data.ch   = jse_pkg::CHR_N;
            end
            jse_pkg::CODE_CR: begin
               push_data.kind = jse_pkg::ESC_PAIR;
               push_data.ch   = jse_pkg::CHR_R;
            end
            jse_pkg::CODE_TAB: begin
               push_data.kind = jse_pkg::ESC_PAIR;
               push_data.ch   = jse_pkg::CHR_T;
            end
            default: begin
               if (req.data_byte < jse_pkg::CTRL_LIMIT ||
                   req.data_byte >= jse_pkg::HIGH_LIMIT) begin
                  push_data.kind = jse_pkg::ESC_UNI;
               end
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ rtl/jse_queue.sv @@
// Small descriptor FIFO between the classifier and the emitter.
`timescale 1ns / 1ps
`default_nettype none

module jse_queue #(
   parameter int DEPTH = jse_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  jse_pkg::desc_type     push_data,
   output logic                  pop_valid,
   input  logic                  pop,
   output jse_pkg::desc_type     pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   jse_pkg::desc_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/jse_back.sv @@
// Back end: feeds descriptors to the response register, one char per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module jse_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  jse_pkg::desc_type     head,
   output logic                  pop,
   jse_rsp_if.source             rsp
);

   logic [2:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       run_end_ff, run_end_in;

   logic [2:0] body_len;
   logic [3:0] total;
   logic [2:0] idx;
   logic       advance;
   logic       is_last;
   logic [7:0] ch;

   assign rsp.valid    = valid_ff;
   assign rsp.out_byte = out_byte_ff;
   assign rsp.run_end  = run_end_ff;

   assign body_len = jse_pkg::esc_len(head.kind);
   assign total    = {1'b0, body_len} + {3'b000, head.open_q} + {3'b000, head.close_q};
   assign idx      = step_ff - {2'b00, head.open_q};
   assign advance  = head_valid && (!valid_ff || rsp.ready);
   assign is_last  = ({1'b0, step_ff} == (total - 4'd1));
   assign pop      = advance && is_last;

   // Character at the current step: opening quote, escape body, closing quote
   always_comb begin
      ch = head.ch;
      if (head.open_q && step_ff == 3'd0) begin
         ch = jse_pkg::CHR_QUOTE;
      end else if (idx == body_len) begin
         ch = jse_pkg::CHR_QUOTE;
      end else begin
         case (head.kind)
            jse_pkg::ESC_PAIR: begin
               ch = (idx == 3'd0) ? jse_pkg::CHR_BSLASH : head.ch;
            end
            jse_pkg::ESC_UNI: begin
               case (idx)
                  3'd0:     ch = jse_pkg::CHR_BSLASH;
                  3'd1:     ch = jse_pkg::CHR_U;
                  3'd2:     ch = jse_pkg::CHR_ZERO;
                  3'd3:     ch = jse_pkg::CHR_ZERO;
                  3'd4:     ch = jse_pkg::hex_digit(head.ch[7:4]);
                  default:  ch = jse_pkg::hex_digit(head.ch[3:0]);
               endcase
            end
            default: ch = head.ch;
         endcase
      end
   end

   always_comb begin
      step_in     = step_ff;
      valid_in    = valid_ff;
      out_byte_in = out_byte_ff;
      run_end_in  = run_end_ff;
      if (valid_ff && rsp.ready) begin
         valid_in = 1'b0;
      end
      if (advance) begin
         valid_in    = 1'b1;
         out_byte_in = ch;
         run_end_in  = is_last;
         step_in     = is_last ? 3'd0 : step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
      out_byte_ff <= out_byte_in;
      run_end_ff  <= run_end_in;
   end

endmodule

`default_nettype wire

@@ rtl/json_string_escaper_unit.sv @@
// Top level of the JSON string escaper: classifier, descriptor queue and character emitter.
// The first output character passes through the descriptor queue and then the response register.
// Throughput: one output character per cycle while the response side accepts; an item producing N characters (1 to 8)
// holds the emitter until its last character is emitted, so plain bytes inside a string sustain one item per cycle.
// The two-entry descriptor queue lets the request side keep accepting, until it fills, while output stalls.
// Reset (synchronous) empties the queue and the response register; nothing else is kept.
`timescale 1ns / 1ps
`default_nettype none

module json_string_escaper_unit #(
   parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   jse_req_if.sink    req,
   jse_rsp_if.source  rsp
);

   logic              push_valid;
   logic              push_ready;
   jse_pkg::desc_type push_data;
   logic              head_valid;
   logic              pop;
   jse_pkg::desc_type head;

   jse_front u_front (
      .req        (req),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   jse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (head_valid),
      .pop        (pop),
      .pop_data   (head)
   );

   jse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule

`default_nettype wire
